// ===== rtl/core/nfa_sa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_sa_pkg
// Shared types and constants of the NFA string acceptor: stream packing,
// item kinds, register addresses and the edge table entry layout.
// ----------------------------------------------------------------------------
package nfa_sa_pkg;

    // Stream payload widths; the tdata widths are padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;

    // Configuration port address width (two 32-bit registers).
    localparam int ADDR_W = 3;

    // Item kinds carried in the low bits of the input tuser.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_CHAR  = 2'd1;
    localparam logic [1:0] MODE_EMPTY = 2'd2;

    // Register select, taken from paddr[2].
    localparam logic REG_FINAL_MASK = 1'b0;
    localparam logic REG_EDGE_COUNT = 1'b1;

    // One edge table entry: source state, symbol byte, target state.
    typedef struct packed {
        logic [4:0] src;
        logic [7:0] sym;
        logic [4:0] dst;
    } edge_t;

    localparam int EDGE_W = $bits(edge_t);

endpackage

// ===== rtl/core/nfa_sa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_sa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nfa_sa_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/nfa_string_acceptor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_string_acceptor_top
// Epsilon-free NFA simulator: loads edges into a table and steps a bitset of
// active states over a byte string, reporting acceptance at string end.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries three kinds of transfer, selected by s_tuser[1:0].
// A load transfer writes one edge into the edge table.
// A character transfer steps the active state set; s_tuser[2] restarts the
// set at state zero and s_tlast marks the final character of the string.
// An empty-string query reports state zero alone against final_mask.
// A character walks the loaded edges one per cycle through a single compare
// unit fed by the edge table RAM (edge_count clipped to EDGES); s_tready
// stays low while the walk runs and, for the final character of a string,
// until its result moves into the output register.
// A final character's result is formed in the DONE state after its walk;
// an empty-string query goes to the DONE state directly.
// Results leave through one output register on the m_ stream. If the
// receiver stalls, the block still takes loads and non-final characters;
// a second result waits in the sequencer until the register frees up.
// Reset clears final_mask and edge_count and sets the active set to state
// zero; the edge table content is undefined until loaded. The user must write
// the APB port only while no work is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module nfa_string_acceptor_top #(
    parameter int STATES = 32,
    parameter int EDGES  = 128
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // edge_slot[6:0], edge_from[11:7], edge_symbol[19:12], edge_to[24:20],
    // symbol[32:25], zero fill [39:33]
    input  logic [nfa_sa_pkg::IN_TDATA_W-1:0]      s_tdata,
    // mode[1:0], first[2]
    input  logic [nfa_sa_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                   s_tlast,

    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // accepted[0], active_states[32:1], zero fill [39:33]
    output logic [nfa_sa_pkg::OUT_TDATA_W-1:0]     m_tdata,

    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [nfa_sa_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    import nfa_sa_pkg::*;

    // Table address width, and a count width that can also hold EDGES.
    localparam int AW = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int CW = $clog2(EDGES + 1);
    localparam logic [15:0] EDGES_W = 16'(EDGES);
    // States at or above STATES never become active.
    localparam logic [31:0] STATE_MASK =
        (STATES >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << STATES) - 64'd1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration registers.
    logic [31:0]   final_mask_reg;
    logic [7:0]    edge_count_reg;

    // Sequencer and datapath registers.
    logic [1:0]    state_reg, state_next;
    logic [31:0]   active_reg, active_next;
    logic [31:0]   acc_reg, acc_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [7:0]    sym_reg, sym_next;
    logic          last_reg, last_next;
    logic          pend_reg, pend_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Input field views.
    logic [1:0]    in_mode;
    logic          in_first;
    logic [6:0]    in_slot;
    edge_t         in_edge;
    logic [7:0]    in_symbol;
    logic          in_fire;

    // Edge table access.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    edge_t         ram_rdata;
    logic [15:0]   slot_ext;
    logic [15:0]   cnt_ext;
    logic [15:0]   cnt_clip;

    // Compare unit.
    logic          issue;
    logic          hit;
    logic [31:0]   dst_bit;
    logic          out_free;

    assign in_mode     = s_tuser[1:0];
    assign in_first    = s_tuser[2];
    assign in_slot     = s_tdata[6:0];
    assign in_edge.src = s_tdata[11:7];
    assign in_edge.sym = s_tdata[19:12];
    assign in_edge.dst = s_tdata[24:20];
    assign in_symbol   = s_tdata[32:25];

    // Loads and characters are only taken while the sequencer is idle.
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            REG_FINAL_MASK: prdata = final_mask_reg;
            REG_EDGE_COUNT: prdata = {24'd0, edge_count_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_mask_reg <= 32'd0;
            edge_count_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_FINAL_MASK)
            begin
                final_mask_reg <= pwdata;
            end
            else
            begin
                edge_count_reg <= pwdata[7:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Edge table.
    // ------------------------------------------------------------------
    // Slots beyond the table are dropped; edge counts beyond it are clipped.
    assign slot_ext  = {9'd0, in_slot};
    assign ram_waddr = slot_ext[AW-1:0];
    assign ram_we    = in_fire && (in_mode == MODE_LOAD) && (slot_ext < EDGES_W);
    assign cnt_ext   = {8'd0, edge_count_reg};
    assign cnt_clip  = (cnt_ext > EDGES_W) ? EDGES_W : cnt_ext;
    assign ram_raddr = idx_reg[AW-1:0];

    nfa_sa_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_edge),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Compare unit: one table entry per cycle. The read issued in one
    // cycle is compared in the next, so the walk ends with a compare after its last read.
    // ------------------------------------------------------------------
    assign issue   = (state_reg == ST_RUN) && (idx_reg < n_reg);
    assign dst_bit = (32'd1 << ram_rdata.dst) & STATE_MASK;
    assign hit     = pend_reg && (ram_rdata.sym == sym_reg)
                     && active_reg[ram_rdata.src];

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        pend_next      = issue;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_mode)
                        MODE_CHAR:
                        begin
                            if (in_first)
                            begin
                                active_next = 32'd1;
                            end
                            acc_next   = 32'd0;
                            idx_next   = '0;
                            n_next     = cnt_clip[CW-1:0];
                            sym_next   = in_symbol;
                            last_next  = s_tlast;
                            state_next = ST_RUN;
                        end
                        MODE_EMPTY:
                        begin
                            acc_next    = 32'd1;
                            active_next = 32'd1;
                            state_next  = ST_DONE;
                        end
                        default:
                        begin
                            // Loads write the table directly; mode 3 is a no-op.
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (hit)
                begin
                    acc_next = acc_reg | dst_bit;
                end
                if (!issue && !pend_reg)
                begin
                    if (last_reg)
                    begin
                        active_next = 32'd1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        active_next = acc_reg;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, acc_reg,
                                      |(acc_reg & final_mask_reg & STATE_MASK)};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 32'd1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // A pending table read only exists while the edge walk runs.
    a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_RUN))
        else $error("edge read pending outside the walk");

    // The walk index never passes the clipped edge count.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (idx_reg <= n_reg))
        else $error("edge index ran past the edge count");

    // A finished result holds in the sequencer while the output is stalled.
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !m_tready)
        |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

    // The accept flag agrees with the reported set and the final states.
    a_accept_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == |(m_tdata[32:1] & final_mask_reg & STATE_MASK)))
        else $error("accept flag disagrees with active states");

    // States beyond the configured count never show up in a result.
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[32:1] & ~STATE_MASK) == 32'd0))
        else $error("out-of-range state reported active");
`endif

endmodule
